// ----- design/psched_pkg.sv -----
// Package for the priority channel scheduler: codes, field widths and parameter defaults.
`default_nettype none
package psched_pkg;

  localparam int NumChannelsDef = 32;
  localparam int QueueDepthDef  = 64;

  localparam int KindW   = 3;
  localparam int StatusW = 3;
  localparam int InDataW  = 176;
  localparam int OutDataW = 184;

  localparam logic [KindW-1:0] K_REGISTER = 3'd0;
  localparam logic [KindW-1:0] K_SUBMIT   = 3'd1;
  localparam logic [KindW-1:0] K_NEXT     = 3'd2;
  localparam logic [KindW-1:0] K_YIELD    = 3'd3;
  localparam logic [KindW-1:0] K_SETCTX   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_REJECTED = 3'd1;
  localparam logic [StatusW-1:0] ST_IGNORED  = 3'd2;
  localparam logic [StatusW-1:0] ST_NONE     = 3'd3;
  localparam logic [StatusW-1:0] ST_OVERFLOW = 3'd4;

  localparam logic [1:0] Q_HIGH   = 2'd0;
  localparam logic [1:0] Q_NORMAL = 2'd1;
  localparam logic [1:0] Q_LOW    = 2'd2;
  localparam logic [1:0] Q_END    = 2'd3;

endpackage
`default_nettype wire

// ----- design/priority_channel_scheduler.sv -----
// Strict-priority channel scheduler: three id queues in one memory, starvation counter.
// Flow: register, submit, yield, set context and a next with no registered channel
//   go straight to the result; any other next reads queue entries one at a time
//   (preemption scan, starvation pops, stale fronts, the granted front) and steps over
//   empty queues; a stalled result holds the block until it is taken.
// Throughput: one transaction in flight; the next is taken once the result is registered.
// Reset: rst_n synchronous, active low; clears channel flags, queue pointers, counters;
//   queue and batch memories are not cleared.
`default_nettype none
module priority_channel_scheduler #(
  parameter int NUM_CHANNELS = psched_pkg::NumChannelsDef,
  parameter int QUEUE_DEPTH  = psched_pkg::QueueDepthDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // channel[5:0], priority_req[7:6], context_green[8], batch_address[72:9],
  // batch_count[104:73], fence_value[168:105], zero fill above
  input  wire logic [psched_pkg::InDataW-1:0] in_tdata,
  // kind[2:0]
  input  wire logic [psched_pkg::KindW-1:0]  in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // grant_valid[0], grant_channel[6:1], grant_address[70:7], grant_count[102:71],
  // grant_fence[166:103], preempt_valid[167], preempt_channel[173:168],
  // active_channels[180:174], zero fill above
  output logic [psched_pkg::OutDataW-1:0]    out_tdata,
  // status[2:0]
  output logic [psched_pkg::StatusW-1:0]     out_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [7:0]                    cfg_data
);
  import psched_pkg::*;

  localparam int QD  = QUEUE_DEPTH;
  localparam int CHW = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
  localparam int UW  = $clog2(QD + 1);
  localparam int HW  = $clog2(QD);
  localparam int QA  = $clog2(3 * QD);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PRE_RD   = 4'd1;
  localparam logic [3:0] S_PRE_CHK  = 4'd2;
  localparam logic [3:0] S_STV_RD   = 4'd3;
  localparam logic [3:0] S_STV_CHK  = 4'd4;
  localparam logic [3:0] S_PRI_RD   = 4'd5;
  localparam logic [3:0] S_PRI_CHK  = 4'd6;
  localparam logic [3:0] S_GRANT_RD = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  // input fields
  logic [5:0]  in_ch;
  logic [1:0]  in_prio;
  logic        in_green;
  logic [63:0] in_addr;
  logic [31:0] in_count;
  logic [63:0] in_fence;
  logic [CHW-1:0] in_idx;
  logic        in_fire, in_ok, in_reg;

  // state
  logic [3:0]  state_r, state_nxt;
  logic [NUM_CHANNELS-1:0] reg_r, reg_nxt, fl_r, fl_nxt, green_r, green_nxt;
  logic [1:0]  prio_r [NUM_CHANNELS];
  logic [1:0]  prio_nxt [NUM_CHANNELS];
  logic [HW-1:0] head_r [3];
  logic [HW-1:0] head_nxt [3];
  logic [UW-1:0] used_r [3];
  logic [UW-1:0] used_nxt [3];
  logic [7:0]  scount_r, scount_nxt, limit_r, limit_nxt;
  logic [6:0]  active_r, active_nxt;
  logic        last_v_r, last_v_nxt;
  logic [CHW-1:0] last_r, last_nxt;
  logic [1:0]  qsel_r, qsel_nxt;
  logic [UW-1:0] k_r, k_nxt;
  logic [StatusW-1:0] res_status_r, res_status_nxt;
  logic        res_gv_r, res_gv_nxt, res_pv_r, res_pv_nxt;
  logic [CHW-1:0] res_gch_r, res_gch_nxt, res_pch_r, res_pch_nxt;
  logic        out_valid_r, out_valid_nxt, out_load;

  assign in_ch    = in_tdata[5:0];
  assign in_prio  = in_tdata[7:6];
  assign in_green = in_tdata[8];
  assign in_addr  = in_tdata[72:9];
  assign in_count = in_tdata[104:73];
  assign in_fence = in_tdata[168:105];
  assign in_idx   = in_ch[CHW-1:0];
  assign in_ok    = 7'(in_ch) < 7'(NUM_CHANNELS);
  assign in_reg   = in_ok && reg_r[in_idx];

  // memories
  logic [CHW-1:0] qmem [3*QD];
  logic [CHW-1:0] q_rd_r;
  logic        q_we, q_re;
  logic [QA-1:0] q_wa, q_ra;
  logic [CHW-1:0] q_wd;
  logic [63:0] cmem_addr [NUM_CHANNELS];
  logic [31:0] cmem_count [NUM_CHANNELS];
  logic [63:0] cmem_fence [NUM_CHANNELS];
  logic [63:0] c_addr_rd_r, c_fence_rd_r;
  logic [31:0] c_count_rd_r;
  logic        c_we, c_re;
  logic [CHW-1:0] c_ra;

  logic [StatusW-1:0] o_status_r;
  logic        o_gv_r, o_pv_r;
  logic [5:0]  o_gch_r, o_pch_r;
  logic [63:0] o_addr_r, o_fence_r;
  logic [31:0] o_count_r;
  logic [6:0]  o_active_r;

  function automatic logic [QA-1:0] qaddr(input logic [1:0] q, input logic [HW-1:0] h,
                                          input logic [UW-1:0] k);
    logic [UW:0] s;
    logic [QA-1:0] base;
    s = (UW+1)'(h) + (UW+1)'(k);
    if (s >= (UW+1)'(QD)) s = s - (UW+1)'(QD);
    case (q)
      Q_HIGH:   base = '0;
      Q_NORMAL: base = QA'(QD);
      default:  base = QA'(2 * QD);
    endcase
    return base + QA'(s);
  endfunction

  function automatic logic [HW-1:0] hinc(input logic [HW-1:0] h);
    return (h == HW'(QD - 1)) ? '0 : h + HW'(1);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [CHW-1:0] c;
    logic [1:0] pq;
    logic go_grant;
    state_nxt = state_r;
    reg_nxt = reg_r; fl_nxt = fl_r; green_nxt = green_r;
    prio_nxt = prio_r; head_nxt = head_r; used_nxt = used_r;
    scount_nxt = scount_r; active_nxt = active_r;
    last_v_nxt = last_v_r; last_nxt = last_r;
    qsel_nxt = qsel_r; k_nxt = k_r;
    res_status_nxt = res_status_r; res_gv_nxt = res_gv_r; res_pv_nxt = res_pv_r;
    res_gch_nxt = res_gch_r; res_pch_nxt = res_pch_r;
    limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_load = 1'b0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_re = 1'b0; q_ra = '0;
    c_we = 1'b0; c_re = 1'b0; c_ra = '0;
    c = q_rd_r;
    pq = '0;
    go_grant = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_gv_nxt = 1'b0; res_pv_nxt = 1'b0;
          res_gch_nxt = '0; res_pch_nxt = '0;
          res_status_nxt = ST_IGNORED;
          state_nxt = S_FIN;
          case (in_tuser)
            K_REGISTER: begin
              if (!in_ok || in_reg || in_prio == Q_END) begin
                res_status_nxt = ST_REJECTED;
              end else begin
                reg_nxt[in_idx] = 1'b1;
                fl_nxt[in_idx] = 1'b0;
                prio_nxt[in_idx] = in_prio;
                green_nxt[in_idx] = in_green;
                active_nxt = active_r + 7'd1;
                if (used_r[in_prio] < UW'(QD)) begin
                  q_we = 1'b1;
                  q_wa = qaddr(in_prio, head_r[in_prio], used_r[in_prio]);
                  q_wd = in_idx;
                  used_nxt[in_prio] = used_r[in_prio] + UW'(1);
                  res_status_nxt = ST_OK;
                end else begin
                  res_status_nxt = ST_OVERFLOW;
                end
              end
            end
            K_SUBMIT: begin
              if (in_reg) begin
                c_we = 1'b1;
                res_status_nxt = ST_OK;
                if (!fl_r[in_idx]) begin
                  pq = prio_r[in_idx];
                  if (used_r[pq] < UW'(QD)) begin
                    q_we = 1'b1;
                    q_wa = qaddr(pq, head_r[pq], used_r[pq]);
                    q_wd = in_idx;
                    used_nxt[pq] = used_r[pq] + UW'(1);
                    fl_nxt[in_idx] = 1'b1;
                  end else begin
                    res_status_nxt = ST_OVERFLOW;
                  end
                end
              end
            end
            K_YIELD: begin
              if (in_reg) begin
                fl_nxt[in_idx] = 1'b0;
                res_status_nxt = ST_OK;
              end
            end
            K_SETCTX: begin
              if (in_reg) begin
                green_nxt[in_idx] = in_green;
                res_status_nxt = ST_OK;
              end
            end
            K_NEXT: begin
              res_status_nxt = ST_NONE;
              if (active_r != 7'd0) begin
                if (last_v_r && reg_r[last_r] && green_r[last_r] && fl_r[last_r]) begin
                  state_nxt = S_PRE_RD;
                  qsel_nxt = Q_HIGH;
                  k_nxt = '0;
                end else begin
                  go_grant = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PRE_RD: begin
        if (qsel_r == Q_LOW) begin
          go_grant = 1'b1;
        end else if (k_r >= used_r[qsel_r]) begin
          qsel_nxt = qsel_r + 2'd1;
          k_nxt = '0;
        end else begin
          q_re = 1'b1;
          q_ra = qaddr(qsel_r, head_r[qsel_r], k_r);
          state_nxt = S_PRE_CHK;
        end
      end
      S_PRE_CHK: begin
        if (c != last_r && fl_r[c] && !green_r[c]) begin
          res_pv_nxt = 1'b1;
          res_pch_nxt = last_r;
          fl_nxt[last_r] = 1'b0;
          pq = prio_r[last_r];
          // re-queue; a full queue drops it, the entry would be stale anyway
          if (used_r[pq] < UW'(QD)) begin
            q_we = 1'b1;
            q_wa = qaddr(pq, head_r[pq], used_r[pq]);
            q_wd = last_r;
            used_nxt[pq] = used_r[pq] + UW'(1);
          end
          go_grant = 1'b1;
        end else begin
          k_nxt = k_r + UW'(1);
          state_nxt = S_PRE_RD;
        end
      end
      S_STV_RD: begin
        if (used_r[Q_LOW] == '0) begin
          state_nxt = S_PRI_RD;
          qsel_nxt = Q_HIGH;
        end else begin
          q_re = 1'b1;
          q_ra = qaddr(Q_LOW, head_r[Q_LOW], '0);
          state_nxt = S_STV_CHK;
        end
      end
      S_STV_CHK: begin
        head_nxt[Q_LOW] = hinc(head_r[Q_LOW]);
        used_nxt[Q_LOW] = used_r[Q_LOW] - UW'(1);
        if (fl_r[c]) begin
          res_gv_nxt = 1'b1;
          res_gch_nxt = c;
          state_nxt = S_GRANT_RD;
        end else begin
          state_nxt = S_STV_RD;
        end
      end
      S_PRI_RD: begin
        if (qsel_r == Q_END) begin
          state_nxt = S_FIN;
        end else if (used_r[qsel_r] == '0) begin
          qsel_nxt = qsel_r + 2'd1;
        end else begin
          q_re = 1'b1;
          q_ra = qaddr(qsel_r, head_r[qsel_r], '0);
          state_nxt = S_PRI_CHK;
        end
      end
      S_PRI_CHK: begin
        if (!fl_r[c]) begin
          // stale entry, drop it from the front
          head_nxt[qsel_r] = hinc(head_r[qsel_r]);
          used_nxt[qsel_r] = used_r[qsel_r] - UW'(1);
          state_nxt = S_PRI_RD;
        end else begin
          res_gv_nxt = 1'b1;
          res_gch_nxt = c;
          if (qsel_r == Q_LOW) scount_nxt = '0;
          else if (scount_r != 8'hff) scount_nxt = scount_r + 8'd1;
          state_nxt = S_GRANT_RD;
        end
      end
      S_GRANT_RD: begin
        last_v_nxt = 1'b1;
        last_nxt = res_gch_r;
        res_status_nxt = ST_OK;
        c_re = 1'b1;
        c_ra = res_gch_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (go_grant) begin
      if (scount_r >= limit_r) begin
        scount_nxt = '0;
        state_nxt = S_STV_RD;
      end else begin
        qsel_nxt = Q_HIGH;
        state_nxt = S_PRI_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      reg_r <= '0;
      fl_r <= '0;
      head_r <= '{default: '0};
      used_r <= '{default: '0};
      scount_r <= '0;
      limit_r <= 8'd8;
      active_r <= '0;
      last_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reg_r <= reg_nxt;
      fl_r <= fl_nxt;
      head_r <= head_nxt;
      used_r <= used_nxt;
      scount_r <= scount_nxt;
      limit_r <= limit_nxt;
      active_r <= active_nxt;
      last_v_r <= last_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    green_r <= green_nxt;
    prio_r <= prio_nxt;
    last_r <= last_nxt;
    qsel_r <= qsel_nxt;
    k_r <= k_nxt;
    res_status_r <= res_status_nxt;
    res_gv_r <= res_gv_nxt;
    res_pv_r <= res_pv_nxt;
    res_gch_r <= res_gch_nxt;
    res_pch_r <= res_pch_nxt;
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_wa] <= q_wd;
    if (q_re) q_rd_r <= qmem[q_ra];
  end

  // batch memory
  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem_addr[in_idx] <= in_addr;
      cmem_count[in_idx] <= in_count;
      cmem_fence[in_idx] <= in_fence;
    end
    if (c_re) begin
      c_addr_rd_r <= cmem_addr[c_ra];
      c_count_rd_r <= cmem_count[c_ra];
      c_fence_rd_r <= cmem_fence[c_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r <= res_status_r;
      o_gv_r <= res_gv_r;
      o_gch_r <= res_gv_r ? 6'(res_gch_r) : 6'd0;
      o_addr_r <= res_gv_r ? c_addr_rd_r : 64'd0;
      o_count_r <= res_gv_r ? c_count_rd_r : 32'd0;
      o_fence_r <= res_gv_r ? c_fence_rd_r : 64'd0;
      o_pv_r <= res_pv_r;
      o_pch_r <= res_pv_r ? 6'(res_pch_r) : 6'd0;
      o_active_r <= active_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {3'd0, o_active_r, o_pch_r, o_pv_r, o_fence_r, o_count_r,
                       o_addr_r, o_gch_r, o_gv_r};

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[0] <= UW'(QD) && used_r[1] <= UW'(QD) && used_r[2] <= UW'(QD))
    else $error("queue fill above depth");

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= 7'(NUM_CHANNELS))
    else $error("active channel count above channel count");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tuser == ST_OK)
    else $error("grant with non-ok status");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_valid_r && !out_tready |=> state_r == S_FIN)
    else $error("result overwrote a pending transaction");

endmodule
`default_nettype wire

// ----- tb/sv/priority_channel_scheduler_tb.sv -----
// Self-checking testbench for the priority channel scheduler: directed table, then random traffic.
module priority_channel_scheduler_tb;
  import psched_pkg::*;

  localparam int NCH       = 32;
  localparam int QDEPTH    = 64;
  localparam int CYCLE_CAP = 1500000;
  localparam logic [KindW-1:0] K_SPARE_LO = 3'd5;
  localparam logic [KindW-1:0] K_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [5:0]       channel;
    logic [1:0]       prio;
    logic             green;
    logic [63:0]      addr;
    logic [31:0]      count;
    logic [63:0]      fence;
  } sched_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               grant_valid;
    logic [5:0]         grant_channel;
    logic [63:0]        grant_address;
    logic [31:0]        grant_count;
    logic [63:0]        grant_fence;
    logic               preempt_valid;
    logic [5:0]         preempt_channel;
    logic [6:0]         active_channels;
  } sched_result_t;

  typedef struct {
    sched_cmd_t         cmd;
    bit                 typed;
    logic [StatusW-1:0] status;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic [KindW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [StatusW-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  priority_channel_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // scheduler shadow state
  bit          chan_registered [NCH];
  bit          chan_in_flight [NCH];
  logic [1:0]  chan_prio [NCH];
  bit          chan_green [NCH];
  logic [63:0] chan_addr [NCH];
  logic [31:0] chan_count [NCH];
  logic [63:0] chan_fence [NCH];
  logic [4:0]  prio_queue [3][$];
  logic [7:0]  starve_count = 0;
  bit          last_valid = 0;
  logic [4:0]  last_granted = 0;
  logic [6:0]  active_total = 0;
  logic [7:0]  starve_limit = 8'd8;

  sched_result_t pending_results[$];
  int  error_count = 0;
  int  results_seen = 0;
  int  grants_seen = 0;
  int  preempts_seen = 0;
  int  overflows_seen = 0;
  int  cycle_count = 0;
  bit  quiet = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;

  function automatic bit is_live(logic [4:0] id);
    return chan_in_flight[id];
  endfunction

  function automatic sched_result_t schedule_step(sched_cmd_t c);
    sched_result_t r;
    bit ok_ch, is_reg, pv, gv;
    logic [4:0] id, cand, gch, pch;
    r = '0;
    pv = 0;
    gv = 0;
    gch = 0;
    pch = 0;
    id = c.channel[4:0];
    ok_ch = c.channel < NCH;
    is_reg = ok_ch && chan_registered[id];
    r.status = ST_IGNORED;
    case (c.kind)
      K_REGISTER: begin
        if (!ok_ch || is_reg || c.prio == Q_END) begin
          r.status = ST_REJECTED;
        end else begin
          chan_registered[id] = 1;
          chan_in_flight[id] = 0;
          chan_count[id] = 0;
          chan_fence[id] = 0;
          chan_prio[id] = c.prio;
          chan_green[id] = c.green;
          active_total++;
          if (prio_queue[c.prio].size() < QDEPTH) begin
            prio_queue[c.prio].push_back(id);
            r.status = ST_OK;
          end else begin
            r.status = ST_OVERFLOW;
          end
        end
      end
      K_SUBMIT: begin
        if (is_reg) begin
          chan_addr[id] = c.addr;
          chan_count[id] = c.count;
          chan_fence[id] = c.fence;
          r.status = ST_OK;
          if (!chan_in_flight[id]) begin
            if (prio_queue[chan_prio[id]].size() < QDEPTH) begin
              prio_queue[chan_prio[id]].push_back(id);
              chan_in_flight[id] = 1;
            end else begin
              r.status = ST_OVERFLOW;
            end
          end
        end
      end
      K_YIELD: begin
        if (is_reg) begin
          chan_in_flight[id] = 0;
          r.status = ST_OK;
        end
      end
      K_SETCTX: begin
        if (is_reg) begin
          chan_green[id] = c.green;
          r.status = ST_OK;
        end
      end
      K_NEXT: begin
        r.status = ST_NONE;
        if (active_total != 0) begin
          // green last grant yields to any live brown channel in high or normal
          if (last_valid && chan_registered[last_granted] && chan_green[last_granted] &&
              chan_in_flight[last_granted]) begin
            for (int q = 0; q < 2 && !pv; q++) begin
              foreach (prio_queue[q][k]) begin
                cand = prio_queue[q][k];
                if (cand != last_granted && is_live(cand) && !chan_green[cand]) pv = 1;
              end
            end
            if (pv) begin
              pch = last_granted;
              chan_in_flight[last_granted] = 0;
              if (prio_queue[chan_prio[last_granted]].size() < QDEPTH)
                prio_queue[chan_prio[last_granted]].push_back(last_granted);
            end
          end
          if (starve_count >= starve_limit) begin
            while (prio_queue[Q_LOW].size() != 0 && !gv) begin
              cand = prio_queue[Q_LOW].pop_front();
              if (is_live(cand)) begin
                gv = 1;
                gch = cand;
              end
            end
            starve_count = 0;
          end
          for (int q = 0; q < 3 && !gv; q++) begin
            while (prio_queue[q].size() != 0 && !gv) begin
              cand = prio_queue[q][0];
              if (!is_live(cand)) begin
                void'(prio_queue[q].pop_front());
              end else begin
                gv = 1;
                gch = cand;
                if (q == Q_LOW) starve_count = 0;
                else if (starve_count != 8'd255) starve_count++;
              end
            end
          end
          if (gv) begin
            last_valid = 1;
            last_granted = gch;
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    if (gv) begin
      r.grant_valid = 1;
      r.grant_channel = {1'b0, gch};
      r.grant_address = chan_addr[gch];
      r.grant_count = chan_count[gch];
      r.grant_fence = chan_fence[gch];
    end
    if (pv) begin
      r.preempt_valid = 1;
      r.preempt_channel = {1'b0, pch};
    end
    r.active_channels = active_total;
    return r;
  endfunction

  task automatic check_result();
    sched_result_t got, want;
    got.status = out_tuser;
    got.grant_valid = out_tdata[0];
    got.grant_channel = out_tdata[6:1];
    got.grant_address = out_tdata[70:7];
    got.grant_count = out_tdata[102:71];
    got.grant_fence = out_tdata[166:103];
    got.preempt_valid = out_tdata[167];
    got.preempt_channel = out_tdata[173:168];
    got.active_channels = out_tdata[180:174];
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("unexpected result transaction: status %0d", got.status);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.status == ST_OVERFLOW) overflows_seen++;
      if (got.grant_valid) grants_seen++;
      if (got.preempt_valid) preempts_seen++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.grant_valid !== want.grant_valid) begin
        $error("grant_valid: expected %0d, actual %0d", want.grant_valid, got.grant_valid);
        error_count++;
      end
      if (got.grant_channel !== want.grant_channel) begin
        $error("grant_channel: expected %0d, actual %0d", want.grant_channel,
               got.grant_channel);
        error_count++;
      end
      if (got.grant_address !== want.grant_address) begin
        $error("grant_address: expected %h, actual %h", want.grant_address,
               got.grant_address);
        error_count++;
      end
      if (got.grant_count !== want.grant_count) begin
        $error("grant_count: expected %h, actual %h", want.grant_count, got.grant_count);
        error_count++;
      end
      if (got.grant_fence !== want.grant_fence) begin
        $error("grant_fence: expected %h, actual %h", want.grant_fence, got.grant_fence);
        error_count++;
      end
      if (got.preempt_valid !== want.preempt_valid) begin
        $error("preempt_valid: expected %0d, actual %0d", want.preempt_valid,
               got.preempt_valid);
        error_count++;
      end
      if (got.preempt_channel !== want.preempt_channel) begin
        $error("preempt_channel: expected %0d, actual %0d", want.preempt_channel,
               got.preempt_channel);
        error_count++;
      end
      if (got.active_channels !== want.active_channels) begin
        $error("active_channels: expected %0d, actual %0d", want.active_channels,
               got.active_channels);
        error_count++;
      end
    end
  endtask

  // result side: check, then pick next ready value
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(sched_cmd_t c, bit typed, logic [StatusW-1:0] typed_status);
    sched_result_t want;
    in_tvalid <= 1'b1;
    in_tuser <= c.kind;
    in_tdata <= {7'd0, c.fence, c.count, c.addr, c.green, c.prio, c.channel};
    do @(posedge clk); while (!in_tready);
    want = schedule_step(c);
    if (typed) want.status = typed_status;
    pending_results.push_back(want);
    if (!quiet && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    starve_limit = value;
  endtask

  function automatic sched_cmd_t make_cmd(logic [KindW-1:0] kind, logic [5:0] ch,
                                          logic [1:0] prio, logic green,
                                          logic [63:0] addr, logic [31:0] count,
                                          logic [63:0] fence);
    sched_cmd_t c;
    c.kind = kind;
    c.channel = ch;
    c.prio = prio;
    c.green = green;
    c.addr = addr;
    c.count = count;
    c.fence = fence;
    return c;
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c.kind = pick < 8 ? K_REGISTER : pick < 38 ? K_SUBMIT : pick < 73 ? K_NEXT :
             pick < 86 ? K_YIELD : pick < 97 ? K_SETCTX :
             3'($urandom_range(K_SPARE_LO, K_SPARE_HI));
    c.channel = $urandom_range(99) < 92 ? 6'($urandom_range(NCH - 1)) : 6'($urandom_range(63));
    c.prio = $urandom_range(99) < 5 ? Q_END : 2'($urandom_range(2));
    c.green = $urandom_range(1);
    c.addr = {$urandom, $urandom};
    c.count = $urandom;
    c.fence = {$urandom, $urandom};
    return c;
  endfunction

  table_row_t directed[$];

  task automatic add_row(sched_cmd_t c, bit typed, logic [StatusW-1:0] st);
    table_row_t row;
    row.cmd = c;
    row.typed = typed;
    row.status = st;
    directed.push_back(row);
  endtask

  initial begin
    sched_cmd_t c;
    int random_items;
    random_items = 0;
    add_row(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 1, ST_NONE);
    add_row(make_cmd(K_SUBMIT, 5, Q_HIGH, 0, 1, 1, 1), 1, ST_IGNORED);
    add_row(make_cmd(K_YIELD, 40, Q_HIGH, 0, 0, 0, 0), 1, ST_IGNORED);
    add_row(make_cmd(K_REGISTER, 40, Q_HIGH, 0, 0, 0, 0), 1, ST_REJECTED);
    add_row(make_cmd(K_REGISTER, 3, Q_END, 0, 0, 0, 0), 1, ST_REJECTED);
    add_row(make_cmd(K_SPARE_LO, 2, Q_HIGH, 1, 0, 0, 0), 1, ST_IGNORED);
    add_row(make_cmd(K_SPARE_HI, 63, Q_END, 1, '1, '1, '1), 1, ST_IGNORED);
    add_row(make_cmd(K_REGISTER, 0, Q_HIGH, 1, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_REGISTER, 0, Q_LOW, 0, 0, 0, 0), 1, ST_REJECTED);
    add_row(make_cmd(K_REGISTER, 31, Q_NORMAL, 0, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_REGISTER, 1, Q_LOW, 0, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 1, ST_NONE);
    add_row(make_cmd(K_SUBMIT, 0, Q_HIGH, 0, '1, '1, '1), 1, ST_OK);
    add_row(make_cmd(K_SUBMIT, 31, Q_HIGH, 0, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 0, ST_OK);
    add_row(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 0, ST_OK);
    add_row(make_cmd(K_SETCTX, 31, Q_HIGH, 1, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_SETCTX, 50, Q_HIGH, 1, 0, 0, 0), 1, ST_IGNORED);
    add_row(make_cmd(K_YIELD, 1, Q_HIGH, 0, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_SUBMIT, 1, Q_HIGH, 0, 64'h8000_0000_0000_0001, 32'h8000_0001,
                     64'h0123_4567_89ab_cdef), 1, ST_OK);
    add_row(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 0, ST_OK);
    add_row(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 0, ST_OK);
    add_row(make_cmd(K_YIELD, 31, Q_HIGH, 0, 0, 0, 0), 1, ST_OK);
    add_row(make_cmd(K_SUBMIT, 63, Q_HIGH, 0, 0, 0, 0), 1, ST_IGNORED);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(8'd1);

    foreach (directed[i]) send_item(directed[i].cmd, directed[i].typed, directed[i].status);

    // yield/submit churn on one low channel with no picks puts stale ids in its queue
    for (int i = 0; i < 36; i++) begin
      send_item(make_cmd(K_YIELD, 1, Q_HIGH, 0, 0, 0, 0), 0, ST_OK);
      send_item(make_cmd(K_SUBMIT, 1, Q_HIGH, 0, {$urandom, $urandom}, $urandom,
                         {$urandom, $urandom}), 0, ST_OK);
    end
    send_item(make_cmd(K_REGISTER, 20, Q_LOW, 1, 0, 0, 0), 0, ST_OK);
    send_item(make_cmd(K_NEXT, 0, Q_HIGH, 0, 0, 0, 0), 0, ST_OK);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_limit(8'd255);
        1: write_limit(8'($urandom_range(2, 6)));
        2: write_limit(8'd1);
        default: write_limit(8'd8);
      endcase
      quiet = (phase == 2);
      if (phase == 1) hold_requests++;
      for (int i = 0; i < 100; i++) begin
        c = random_cmd();
        send_item(c, 0, ST_OK);
        if (c.kind <= K_SETCTX) random_items++;
        if (phase == 3 && i == 60) drain_results();
      end
    end
    quiet = 0;

    drain_results();
    repeat (50) @(posedge clk);
    $display("%0d random and %0d directed transactions, %0d results checked",
             random_items, directed.size(), results_seen);
    $display("grants %0d, preemptions %0d, overflows %0d, starvation limits 1..255",
             grants_seen, preempts_seen, overflows_seen);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/psched_pkg.sv
design/priority_channel_scheduler.sv
tb/sv/priority_channel_scheduler_tb.sv
